### hw/rtl/psd_pkg.sv
package psd_pkg;

  localparam int CoordW = 24;
  localparam int DiffW = CoordW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int DotW = ProdW + 1;
  localparam int Len2W = ProdW;
  localparam int DeltaW = DiffW + 1;
  localparam int SqW = 2 * DeltaW - 1;
  localparam int SumW = SqW + 1;
  localparam int RootW = SumW / 2;
  localparam int RemW = RootW + 2;
  localparam int DistW = 25;
  localparam int KindW = 2;
  localparam int ParamFracBitsDef = 16;

  localparam logic [KindW-1:0] KindStart = 2'd0;
  localparam logic [KindW-1:0] KindEnd = 2'd1;
  localparam logic [KindW-1:0] KindInterior = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic signed [DiffW-1:0] ax;
    logic signed [DiffW-1:0] ay;
    logic signed [DiffW-1:0] bx;
    logic signed [DiffW-1:0] by;
    logic signed [DiffW-1:0] fx;
    logic signed [DiffW-1:0] fy;
  } geom_t;

endpackage

### hw/rtl/psd_if.sv
interface psd_in_if import psd_pkg::*;;
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] seg_start_x;
  logic signed [CoordW-1:0] seg_start_y;
  logic signed [CoordW-1:0] seg_end_x;
  logic signed [CoordW-1:0] seg_end_y;

  modport source (output valid, point_x, point_y, seg_start_x, seg_start_y, seg_end_x,
                  seg_end_y, input ready);
  modport sink (input valid, point_x, point_y, seg_start_x, seg_start_y, seg_end_x,
                seg_end_y, output ready);
endinterface

interface psd_out_if import psd_pkg::*;;
  logic valid;
  logic ready;
  logic [DistW-1:0] distance;
  logic [KindW-1:0] nearest_kind;

  modport source (output valid, distance, nearest_kind, input ready);
  modport sink (input valid, distance, nearest_kind, output ready);
endinterface

### hw/rtl/psd_front.sv
module psd_front import psd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  logic signed [CoordW-1:0] sx_i,
  input  logic signed [CoordW-1:0] sy_i,
  input  logic signed [CoordW-1:0] ex_i,
  input  logic signed [CoordW-1:0] ey_i,
  output logic                    valid_o,
  output geom_t                   geom_o,
  output logic [Len2W-1:0]        rem_o,
  output logic [Len2W-1:0]        den_o
);

  logic [2:0] v_q;
  geom_t g0_q, g1_q, g2_q, g0_d, g2_d;
  logic signed [ProdW-1:0] bbx_q, bby_q, abx_q, aby_q;
  logic signed [DotW-1:0] len2_s, dot_s;
  logic [KindW-1:0] kind_d;
  logic [Len2W-1:0] rem_q, den_q;

  always_comb begin
    g0_d.kind = KindStart;
    g0_d.ax = DiffW'(px_i) - DiffW'(sx_i);
    g0_d.ay = DiffW'(py_i) - DiffW'(sy_i);
    g0_d.bx = DiffW'(ex_i) - DiffW'(sx_i);
    g0_d.by = DiffW'(ey_i) - DiffW'(sy_i);
    g0_d.fx = DiffW'(px_i) - DiffW'(ex_i);
    g0_d.fy = DiffW'(py_i) - DiffW'(ey_i);
  end

  always_comb begin
    len2_s = DotW'(bbx_q) + DotW'(bby_q);
    dot_s = DotW'(abx_q) + DotW'(aby_q);
    if (len2_s == '0 || dot_s <= 0) begin
      kind_d = KindStart;
    end else if (dot_s >= len2_s) begin
      kind_d = KindEnd;
    end else begin
      kind_d = KindInterior;
    end
  end

  always_comb begin
    g2_d = g1_q;
    g2_d.kind = kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g0_q <= g0_d;
      g1_q <= g0_q;
      bbx_q <= g0_q.bx * g0_q.bx;
      bby_q <= g0_q.by * g0_q.by;
      abx_q <= g0_q.ax * g0_q.bx;
      aby_q <= g0_q.ay * g0_q.by;
      g2_q <= g2_d;
      rem_q <= dot_s[Len2W-1:0];
      den_q <= len2_s[Len2W-1:0];
    end
  end

  assign valid_o = v_q[2];
  assign geom_o = g2_q;
  assign rem_o = rem_q;
  assign den_o = den_q;

endmodule

### hw/rtl/psd_div.sv
module psd_div import psd_pkg::*; #(
  parameter int ParamFracBits = ParamFracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  geom_t                    geom_i,
  input  logic [Len2W-1:0]         rem_i,
  input  logic [Len2W-1:0]         den_i,
  output logic                     valid_o,
  output geom_t                    geom_o,
  output logic [ParamFracBits-1:0] t_o
);

  localparam int P = ParamFracBits;

  logic [P-1:0] v_q;
  logic [Len2W-1:0] rem_s [P+1];
  logic [Len2W-1:0] den_s [P+1];
  logic [P-1:0] t_s [P+1];
  geom_t g_s [P+1];
  logic [Len2W-1:0] rem_q [P];
  logic [Len2W-1:0] den_q [P];
  logic [P-1:0] t_q [P];
  geom_t g_q [P];

  assign rem_s[0] = rem_i;
  assign den_s[0] = den_i;
  assign t_s[0] = '0;
  assign g_s[0] = geom_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[P-2:0], valid_i};
    end
  end

  // one quotient bit per stage, restoring
  for (genvar i = 0; i < P; i++) begin : g_stage
    logic [Len2W:0] sh;
    logic ge;
    assign sh = {rem_s[i], 1'b0};
    assign ge = sh >= {1'b0, den_s[i]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? Len2W'(sh - {1'b0, den_s[i]}) : sh[Len2W-1:0];
        den_q[i] <= den_s[i];
        t_q[i] <= {t_s[i][P-2:0], ge};
        g_q[i] <= g_s[i];
      end
    end

    assign rem_s[i+1] = rem_q[i];
    assign den_s[i+1] = den_q[i];
    assign t_s[i+1] = t_q[i];
    assign g_s[i+1] = g_q[i];
  end

  assign valid_o = v_q[P-1];
  assign geom_o = g_s[P];
  assign t_o = t_s[P];

endmodule

### hw/rtl/psd_interp.sv
module psd_interp import psd_pkg::*; #(
  parameter int ParamFracBits = ParamFracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  geom_t                    geom_i,
  input  logic [ParamFracBits-1:0] t_i,
  output logic                     valid_o,
  output logic [KindW-1:0]         kind_o,
  output logic [SumW-1:0]          sum_o
);

  localparam int P = ParamFracBits;
  localparam int MulW = DiffW + P + 1;

  logic [3:0] v_q;
  geom_t ga_q;
  logic signed [MulW-1:0] mx_q, my_q;
  logic signed [DeltaW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [KindW-1:0] kb_q, kc_q, kd_q;
  logic signed [2*DeltaW-1:0] px2, py2;
  logic [SqW-1:0] sqx_q, sqy_q;
  logic [SumW-1:0] sum_q;

  assign px2 = dx_q * dx_q;
  assign py2 = dy_q * dy_q;

  // arithmetic shift by P floors the interpolation offset
  always_comb begin
    case (ga_q.kind)
      KindStart: begin
        dx_d = DeltaW'(ga_q.ax);
        dy_d = DeltaW'(ga_q.ay);
      end
      KindEnd: begin
        dx_d = DeltaW'(ga_q.fx);
        dy_d = DeltaW'(ga_q.fy);
      end
      default: begin
        dx_d = DeltaW'(ga_q.ax) - mx_q[P +: DeltaW];
        dy_d = DeltaW'(ga_q.ay) - my_q[P +: DeltaW];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ga_q <= geom_i;
      mx_q <= $signed({1'b0, t_i}) * geom_i.bx;
      my_q <= $signed({1'b0, t_i}) * geom_i.by;
      kb_q <= ga_q.kind;
      dx_q <= dx_d;
      dy_q <= dy_d;
      kc_q <= kb_q;
      sqx_q <= px2[SqW-1:0];
      sqy_q <= py2[SqW-1:0];
      kd_q <= kc_q;
      sum_q <= SumW'(sqx_q) + SumW'(sqy_q);
    end
  end

  assign valid_o = v_q[3];
  assign kind_o = kd_q;
  assign sum_o = sum_q;

endmodule

### hw/rtl/psd_sqrt.sv
module psd_sqrt import psd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [SumW-1:0]  sum_i,
  output logic             valid_o,
  output logic [KindW-1:0] kind_o,
  output logic [RootW-1:0] root_o
);

  logic [RootW-1:0] v_q;
  logic [RemW-1:0] r_s [RootW+1];
  logic [RootW-1:0] q_s [RootW+1];
  logic [SumW-1:0] x_s [RootW+1];
  logic [KindW-1:0] k_s [RootW+1];
  logic [RemW-1:0] r_q [RootW];
  logic [RootW-1:0] q_q [RootW];
  logic [SumW-1:0] x_q [RootW];
  logic [KindW-1:0] k_q [RootW];

  assign r_s[0] = '0;
  assign q_s[0] = '0;
  assign x_s[0] = sum_i;
  assign k_s[0] = kind_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RootW-2:0], valid_i};
    end
  end

  // one root bit per stage: remainder takes the next two radicand bits
  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW+1:0] r_sh;
    logic [RemW+1:0] trial;
    logic ge;
    assign r_sh = {r_s[k], x_s[k][SumW-1 -: 2]};
    assign trial = (RemW+2)'({q_s[k], 2'b01});
    assign ge = r_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= ge ? RemW'(r_sh - trial) : r_sh[RemW-1:0];
        q_q[k] <= {q_s[k][RootW-2:0], ge};
        x_q[k] <= {x_s[k][SumW-3:0], 2'b00};
        k_q[k] <= k_s[k];
      end
    end

    assign r_s[k+1] = r_q[k];
    assign q_s[k+1] = q_q[k];
    assign x_s[k+1] = x_q[k];
    assign k_s[k+1] = k_q[k];
  end

  assign valid_o = v_q[RootW-1];
  assign kind_o = k_s[RootW];
  assign root_o = q_s[RootW];

endmodule

### hw/rtl/point_segment_distance.sv
// Point to 2D segment distance, fully pipelined.
// in_i carries a query point and the segment's start and end (signed Q12.12);
// out_o returns the truncated Euclidean distance (unsigned Q13.12) and which
// part of the segment is nearest (start, end or interior). Both channels use
// valid/ready; a transfer happens when both are high.
// The pipeline runs through the front products, one stage per quotient bit of
// the projection divide, the interpolation and squares, and one stage per root
// bit of the square root.
// Throughput: one item per cycle while out_o is ready.
// When the receiver stalls, the finished item goes into a one-entry skid
// register and in_i.ready drops the cycle after; the whole pipeline then
// holds until the skid entry is taken, so nothing is lost or repeated.
// Reset clears every valid bit; no item is in flight afterwards.
module point_segment_distance import psd_pkg::*; #(
  parameter int ParamFracBits = ParamFracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psd_in_if.sink    in_i,
  psd_out_if.source out_o
);

  logic adv;
  logic fr_valid, dv_valid, ip_valid, sq_valid;
  geom_t fr_geom, dv_geom;
  logic [Len2W-1:0] fr_rem, fr_den;
  logic [ParamFracBits-1:0] dv_t;
  logic [KindW-1:0] ip_kind, sq_kind;
  logic [SumW-1:0] ip_sum;
  logic [RootW-1:0] sq_root;
  logic skid_q, skid_d;
  logic [DistW-1:0] skid_dist_q;
  logic [KindW-1:0] skid_kind_q;

  assign adv = !skid_q;
  assign in_i.ready = adv;

  psd_front u_front (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_i.valid),
    .px_i(in_i.point_x), .py_i(in_i.point_y),
    .sx_i(in_i.seg_start_x), .sy_i(in_i.seg_start_y),
    .ex_i(in_i.seg_end_x), .ey_i(in_i.seg_end_y),
    .valid_o(fr_valid), .geom_o(fr_geom), .rem_o(fr_rem), .den_o(fr_den)
  );

  psd_div #(.ParamFracBits(ParamFracBits)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(fr_valid), .geom_i(fr_geom),
    .rem_i(fr_rem), .den_i(fr_den),
    .valid_o(dv_valid), .geom_o(dv_geom), .t_o(dv_t)
  );

  psd_interp #(.ParamFracBits(ParamFracBits)) u_interp (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv_valid), .geom_i(dv_geom), .t_i(dv_t),
    .valid_o(ip_valid), .kind_o(ip_kind), .sum_o(ip_sum)
  );

  psd_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(ip_valid), .kind_i(ip_kind), .sum_i(ip_sum),
    .valid_o(sq_valid), .kind_o(sq_kind), .root_o(sq_root)
  );

  always_comb begin
    if (!skid_q) begin
      skid_d = sq_valid && !out_o.ready;
    end else begin
      skid_d = !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else begin
      skid_q <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q) begin
      skid_dist_q <= sq_root[DistW-1:0];
      skid_kind_q <= sq_kind;
    end
  end

  assign out_o.valid = skid_q || sq_valid;
  assign out_o.distance = skid_q ? skid_dist_q : sq_root[DistW-1:0];
  assign out_o.nearest_kind = skid_q ? skid_kind_q : sq_kind;

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.nearest_kind != 2'd3))
    else $error("nearest_kind out of range");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(sq_valid && !out_o.ready))
    else $error("skid filled without a stalled result");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(skid_q) |-> $stable(sq_valid))
    else $error("pipeline moved while skid held an item");
`endif

endmodule
